/* hw/rtl/variable_partition_allocator_macros.svh */
// assertion macros for the partition allocator checker
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/vpa_pkg.sv */
// shared types and constants of the partition allocator
package vpa_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned AddrBits   = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam logic [AddrBits-1:0] AMask = '1;

  localparam logic       KindAlloc   = 1'b0;
  localparam logic       KindRelease = 1'b1;
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoFit   = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic       ModeNext    = 1'b0;
  localparam logic       ModeBest    = 1'b1;
  localparam logic [1:0] RegMinSplit = 2'd0;
  localparam logic [1:0] RegFitMode  = 2'd1;

  typedef struct packed {
    logic                kind;
    logic [15:0]         request_size;
    logic [15:0]         release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_address;
    logic [15:0] granted_size;
    logic [4:0]  free_entries;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, clear scan state
    logic scan;       // examine entry at scan index
    logic scan_rst;   // asserted together with load; unused by the datapath
    logic decide;     // evaluate scan outcome, set up action
    logic shift;      // one shift step
    logic finish;     // write final entry, form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic shift_done;
    logic need_shift;
  } sts_t;
endpackage

/* hw/rtl/vpa_if.sv */
// valid/ready channel carrying one payload
interface vpa_if #(parameter type payload_t = logic) (input logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/vpa_ctrl.sv */
// sequencer: scan, decide, shift, finish
module vpa_ctrl import vpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [2:0] {StIdle, StScan, StDecide, StShift, StFinish, StOut} state_e;
  state_e state_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.scan     = (state_q == StScan);
    cmd_o.decide   = (state_q == StDecide);
    // the action is only known once decide has been registered
    cmd_o.shift    = (state_q == StShift) && sts_i.need_shift;
    cmd_o.finish   = (state_q == StFinish);
    cmd_o.scan_rst = cmd_o.load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle:   if (in_valid_i) state_q <= StScan;
        StScan:   if (sts_i.scan_last) state_q <= StDecide;
        StDecide: state_q <= StShift;
        StShift:  if (!sts_i.need_shift || sts_i.shift_done) state_q <= StFinish;
        StFinish: state_q <= StOut;
        StOut:    if (out_ready_i) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end
endmodule

/* hw/rtl/vpa_dp.sv */
// datapath: free table, scan compare, shift and merge
module vpa_dp import vpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  req_t        req_i,
  input  logic [15:0] min_split_i,
  input  logic        fit_mode_i,
  output rsp_t        rsp_o
);
  logic [AddrBits-1:0] start_q [TableDepth];
  logic [AddrBits-1:0] len_q   [TableDepth];
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] rover_q;
  req_t            req_q;
  logic [CntW-1:0] scan_q;     // scan step count
  logic [IdxW-1:0] pos_q;      // physical index under scan
  logic            found_q, below_v_q, above_v_q, pos_v_q;
  logic [IdxW-1:0] hit_q, below_q, above_q, ins_q;
  // action
  typedef enum logic [2:0] {
    ActNone, ActCarve, ActRemove, ActMergeBoth, ActBelow, ActAbove, ActInsert
  } act_e;
  act_e            act_q;
  logic [IdxW-1:0] tgt_q;      // entry written on finish
  logic [IdxW-1:0] del_q;      // entry removed or inserted
  logic [CntW-1:0] sh_q;       // shift cursor
  logic [AddrBits-1:0] wst_q, wln_q;
  logic [1:0]      status_q;
  logic [15:0]     gaddr_q, gsize_q;
  rsp_t            rsp_q;

  logic [AddrBits-1:0] size, raddr;
  logic [AddrBits-1:0] cur_st, cur_ln;
  logic [AddrBits:0]   cur_end, rel_end;
  logic [IdxW-1:0]     first;
  logic [CntW-1:0]     pos_nx;
  logic                fits;

  assign size    = req_q.request_size[AddrBits-1:0];
  assign raddr   = req_q.release_address[AddrBits-1:0];
  assign cur_st  = start_q[pos_q];
  assign cur_ln  = len_q[pos_q];
  assign cur_end = {1'b0, cur_st} + {1'b0, cur_ln};
  assign rel_end = {1'b0, raddr} + {1'b0, size};
  assign fits    = (cur_ln >= size);
  assign first   = ({1'b0, rover_q} < count_q) ? rover_q : '0;
  assign pos_nx  = {1'b0, pos_q} + 1'b1;

  assign sts_o.scan_last  = (scan_q + 1'b1 >= count_q);
  assign sts_o.need_shift = (act_q == ActRemove) || (act_q == ActMergeBoth) ||
                            (act_q == ActInsert);
  assign sts_o.shift_done = (act_q == ActInsert) ? (sh_q <= {1'b0, del_q})
                                                 : (sh_q + 1'b1 >= count_q);
  assign rsp_o = rsp_q;

  // decide-stage sums
  logic [AddrBits+1:0] sum_both;
  logic [AddrBits:0]   sum_below, sum_above;
  logic [AddrBits-1:0] rem;
  assign sum_both  = {2'b0, len_q[below_q]} + {2'b0, size} + {2'b0, len_q[above_q]};
  assign sum_below = {1'b0, len_q[below_q]} + {1'b0, size};
  assign sum_above = {1'b0, len_q[above_q]} + {1'b0, size};
  assign rem       = len_q[hit_q] - size;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.shift) begin
      if (act_q == ActInsert) begin
        if (sh_q > {1'b0, del_q}) begin
          start_q[sh_q[IdxW-1:0]] <= start_q[sh_q[IdxW-1:0] - 1'b1];
          len_q[sh_q[IdxW-1:0]]   <= len_q[sh_q[IdxW-1:0] - 1'b1];
        end
      end else if (sh_q + 1'b1 < count_q) begin
        start_q[sh_q[IdxW-1:0]] <= start_q[sh_q[IdxW-1:0] + 1'b1];
        len_q[sh_q[IdxW-1:0]]   <= len_q[sh_q[IdxW-1:0] + 1'b1];
      end
    end
    if (cmd_i.finish && (act_q != ActNone) && (act_q != ActRemove)) begin
      start_q[tgt_q] <= wst_q;
      len_q[tgt_q]   <= wln_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; rover_q <= '0; scan_q <= '0; pos_q <= '0;
      found_q <= 1'b0; below_v_q <= 1'b0; above_v_q <= 1'b0; pos_v_q <= 1'b0;
      hit_q <= '0; below_q <= '0; above_q <= '0; ins_q <= '0;
      act_q <= ActNone; tgt_q <= '0; del_q <= '0; sh_q <= '0;
      wst_q <= '0; wln_q <= '0; status_q <= StatOk; gaddr_q <= '0; gsize_q <= '0;
      rsp_q <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_q <= '0;
        pos_q  <= (req_i.kind == KindAlloc && fit_mode_i == ModeNext) ? first : '0;
        found_q <= 1'b0; below_v_q <= 1'b0; above_v_q <= 1'b0; pos_v_q <= 1'b0;
      end
      if (cmd_i.scan && count_q != '0) begin
        scan_q <= scan_q + 1'b1;
        pos_q  <= (pos_nx >= count_q) ? '0 : pos_nx[IdxW-1:0];
        if (req_q.kind == KindAlloc) begin
          if (fit_mode_i == ModeBest) begin
            if (fits && (!found_q || cur_ln < len_q[hit_q])) begin
              found_q <= 1'b1; hit_q <= pos_q;
            end
          end else if (fits && !found_q) begin
            found_q <= 1'b1; hit_q <= pos_q;
          end
        end else begin
          if (!below_v_q && cur_end == {1'b0, raddr}) begin
            below_v_q <= 1'b1; below_q <= pos_q;
          end
          if (!above_v_q && {1'b0, cur_st} == rel_end) begin
            above_v_q <= 1'b1; above_q <= pos_q;
          end
          if (!pos_v_q && cur_st > raddr) begin
            pos_v_q <= 1'b1; ins_q <= pos_q;
          end
        end
      end
      if (cmd_i.decide) begin
        act_q <= ActNone; status_q <= StatOk; gaddr_q <= '0; gsize_q <= '0;
        if (req_q.kind == KindAlloc) begin
          if (size == '0 || count_q == '0 || !found_q) begin
            status_q <= StatNoFit;
          end else begin
            gaddr_q <= start_q[hit_q];
            if (fit_mode_i == ModeNext) rover_q <= hit_q;
            if (rem > min_split_i[AddrBits-1:0]) begin
              act_q <= ActCarve; tgt_q <= hit_q;
              wst_q <= start_q[hit_q] + size; wln_q <= rem; gsize_q <= size;
            end else begin
              act_q <= ActRemove; del_q <= hit_q; sh_q <= {1'b0, hit_q};
              gsize_q <= len_q[hit_q];
            end
          end
        end else if (size != '0) begin
          if (below_v_q && above_v_q && !sum_both[AddrBits+1] && !sum_both[AddrBits]) begin
            act_q <= ActMergeBoth; tgt_q <= below_q; del_q <= above_q;
            sh_q <= {1'b0, above_q};
            wst_q <= start_q[below_q]; wln_q <= sum_both[AddrBits-1:0];
          end else if (below_v_q && !sum_below[AddrBits]) begin
            act_q <= ActBelow; tgt_q <= below_q;
            wst_q <= start_q[below_q]; wln_q <= sum_below[AddrBits-1:0];
          end else if (above_v_q && !sum_above[AddrBits]) begin
            act_q <= ActAbove; tgt_q <= above_q;
            wst_q <= raddr; wln_q <= sum_above[AddrBits-1:0];
          end else if (count_q >= CntW'(TableDepth)) begin
            status_q <= StatFull;
          end else begin
            act_q <= ActInsert;
            del_q <= pos_v_q ? ins_q : count_q[IdxW-1:0];
            tgt_q <= pos_v_q ? ins_q : count_q[IdxW-1:0];
            sh_q  <= count_q;
            wst_q <= raddr; wln_q <= size;
          end
        end
      end
      if (cmd_i.shift && !sts_o.shift_done) begin
        sh_q <= (act_q == ActInsert) ? sh_q - 1'b1 : sh_q + 1'b1;
      end
      if (cmd_i.shift && sts_o.shift_done) begin
        if (act_q == ActInsert) begin
          // rover keeps naming the same entry
          logic [CntW-1:0] rv, cnt;
          rv  = {1'b0, rover_q};
          cnt = count_q + 1'b1;
          if (count_q != '0 && del_q <= rover_q) rv = rv + 1'b1;
          if (rv >= cnt) rv = '0;
          rover_q <= rv[IdxW-1:0];
          count_q <= cnt;
        end else begin
          logic [CntW-1:0] rv, cnt;
          rv  = {1'b0, rover_q};
          cnt = count_q - 1'b1;
          if (rover_q > del_q) rv = rv - 1'b1;
          if (rv >= cnt) rv = '0;
          rover_q <= rv[IdxW-1:0];
          count_q <= cnt;
          // merged entry below the removed one keeps its index
          if (act_q == ActMergeBoth && tgt_q > del_q) tgt_q <= tgt_q - 1'b1;
        end
      end
      if (cmd_i.finish) begin
        rsp_q.status        <= status_q;
        rsp_q.grant_address <= gaddr_q;
        rsp_q.granted_size  <= gsize_q;
        rsp_q.free_entries  <= 5'(count_q);
      end
    end
  end
endmodule

/* hw/rtl/variable_partition_allocator.sv */
// from request beat to result valid a request passes through scan, decide, shift and finish
// one request at a time: a new request beat is taken only after the previous result is taken
// the scan visits one entry per cycle; inserts and removals shift one entry per cycle
// reset: empty free table, rover 0, min_split 0, next-fit mode; no clearing pass
// the result is held in an output register until taken
module variable_partition_allocator import vpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpa_if.sink         req_if,
  vpa_if.source       rsp_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] min_split_q;
  logic        fit_mode_q;
  cmd_t        cmd;
  sts_t        sts;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_split_q <= '0;
      fit_mode_q  <= ModeNext;
    end else if (wr) begin
      if (paddr[2] == RegMinSplit[0]) min_split_q <= pwdata[15:0];
      if (paddr[2] == RegFitMode[0])  fit_mode_q  <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegMinSplit[0]: prdata = {16'd0, min_split_q};
      RegFitMode[0]:  prdata = {31'd0, fit_mode_q};
      default:        prdata = '0;
    endcase
  end

  vpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid), .in_ready_o (req_if.ready),
    .out_valid_o(rsp_if.valid), .out_ready_i(rsp_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  vpa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_i(req_if.data),
    .min_split_i(min_split_q), .fit_mode_i(fit_mode_q), .rsp_o(rsp_if.data)
  );
endmodule

/* hw/rtl/vpa_checker.sv */
// port-level assertions for the partition allocator
`include "variable_partition_allocator_macros.svh"
module vpa_checker import vpa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t rsp
);
  `VPA_ASSERT_IMPL(a_status_legal, clk_i, rst_ni, out_valid, rsp.status != 2'd3)
  `VPA_ASSERT_IMPL(a_count_range, clk_i, rst_ni, out_valid, rsp.free_entries <= 5'd16)
  `VPA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid && rsp.status != StatOk,
    rsp.grant_address == '0 && rsp.granted_size == '0)
  `VPA_ASSERT_IMPL(a_one_side, clk_i, rst_ni, out_valid, !in_ready)
  `VPA_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(rsp))
endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_if.valid), .in_ready(req_if.ready),
  .out_valid(rsp_if.valid), .out_ready(rsp_if.ready), .rsp(rsp_if.data)
);

/* bench/variable_partition_allocator_tb.sv */
// testbench for the partition allocator: directed table, then randomized phases
`timescale 1ns / 1ps
module variable_partition_allocator_tb;
  import vpa_pkg::*;

  localparam int MaxCycles = 600000;
  localparam int Drain     = 60;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } vector_t;

  typedef struct {
    logic [15:0] base;
    logic [15:0] len;
  } block_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vpa_if #(.payload_t(req_t)) req_if (clk_i);
  vpa_if #(.payload_t(rsp_t)) rsp_if (clk_i);

  variable_partition_allocator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_if  (req_if),
    .rsp_if  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // allocator shadow state
  logic [15:0] part_base[TableDepth];
  logic [15:0] part_len[TableDepth];
  int          part_cnt;
  int          rover_idx;
  logic [15:0] split_min;
  logic        mode_best;

  rsp_t   pending_rsp[$];
  block_t granted_pool[$];
  int     fail_cnt;
  int     cycle_cnt;
  int     src_idle;
  int     sink_stall;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void drop_part(int idx);
    for (int j = idx; j + 1 < part_cnt; j++) begin
      part_base[j] = part_base[j+1];
      part_len[j]  = part_len[j+1];
    end
    part_cnt--;
    if (rover_idx > idx) rover_idx--;
    if (rover_idx >= part_cnt) rover_idx = 0;
  endfunction

  function automatic rsp_t predict_grant(req_t r);
    rsp_t o;
    int   hit, first, k, pos, lo, hi;
    bit   found, has_lo, has_hi;
    int   sz, ad, fin;
    o     = '0;
    found = 0;
    hit   = 0;
    sz    = r.request_size;
    ad    = r.release_address;
    if (r.kind == KindAlloc) begin
      if (sz != 0 && part_cnt != 0) begin
        if (mode_best == ModeBest) begin
          for (int i = 0; i < part_cnt; i++)
            if (part_len[i] >= sz && (!found || part_len[i] < part_len[hit])) begin
              hit   = i;
              found = 1;
            end
        end else begin
          first = (rover_idx < part_cnt) ? rover_idx : 0;
          for (int i = 0; i < part_cnt && !found; i++) begin
            k = (first + i) % part_cnt;
            if (part_len[k] >= sz) begin
              hit   = k;
              found = 1;
            end
          end
          if (found) rover_idx = hit;
        end
      end
      if (!found) begin
        o.status = StatNoFit;
      end else begin
        o.status        = StatOk;
        o.grant_address = part_base[hit];
        if (int'(part_len[hit]) - sz > int'(split_min)) begin
          part_base[hit] = part_base[hit] + 16'(sz);
          part_len[hit]  = part_len[hit] - 16'(sz);
          o.granted_size = 16'(sz);
        end else begin
          o.granted_size = part_len[hit];
          drop_part(hit);
        end
      end
    end else begin
      o.status = StatOk;
      fin      = ad + sz;
      has_lo   = 0;
      has_hi   = 0;
      lo       = 0;
      hi       = 0;
      if (sz != 0) begin
        for (int i = 0; i < part_cnt; i++) begin
          if (!has_lo && int'(part_base[i]) + int'(part_len[i]) == ad) begin
            lo     = i;
            has_lo = 1;
          end
          if (!has_hi && int'(part_base[i]) == fin) begin
            hi     = i;
            has_hi = 1;
          end
        end
        if (has_lo && has_hi && int'(part_len[lo]) + sz + int'(part_len[hi]) <= 65535) begin
          part_len[lo] = part_len[lo] + 16'(sz) + part_len[hi];
          drop_part(hi);
        end else if (has_lo && int'(part_len[lo]) + sz <= 65535) begin
          part_len[lo] = part_len[lo] + 16'(sz);
        end else if (has_hi && int'(part_len[hi]) + sz <= 65535) begin
          part_base[hi] = 16'(ad);
          part_len[hi]  = part_len[hi] + 16'(sz);
        end else if (part_cnt >= TableDepth) begin
          o.status = StatFull;
        end else begin
          pos = part_cnt;
          for (int i = part_cnt - 1; i >= 0; i--)
            if (int'(part_base[i]) > ad) pos = i;
          for (int j = part_cnt; j > pos; j--) begin
            part_base[j] = part_base[j-1];
            part_len[j]  = part_len[j-1];
          end
          part_base[pos] = 16'(ad);
          part_len[pos]  = 16'(sz);
          if (part_cnt > 0 && pos <= rover_idx) rover_idx++;
          part_cnt++;
          if (rover_idx >= part_cnt) rover_idx = 0;
        end
      end
    end
    o.free_entries = 5'(part_cnt);
    return o;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(idx) << 2;
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == RegMinSplit) split_min = val[15:0];
    else mode_best = val[0];
  endtask

  // drive one beat, hold until taken; called at a falling edge
  task automatic send_req(vector_t v);
    bit   taken;
    rsp_t p;
    while ($urandom_range(0, 99) < src_idle) begin
      req_if.valid = 1'b0;
      req_if.data  = req_t'($urandom);
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = v.req;
    do begin
      #1 taken = req_if.ready;
      if (taken) begin
        p = predict_grant(v.req);
        if (v.typed && p != v.want) begin
          $display("%0t model disagrees with table: want %p got %p", $time, v.want, p);
          fail_cnt++;
        end
        pending_rsp.push_back(p);
        if (v.req.kind == KindAlloc && p.status == StatOk)
          granted_pool.push_back('{p.grant_address, p.granted_size});
      end
      @(negedge clk_i);
    end while (!taken);
    req_if.valid = 1'b0;
  endtask

  // response side: ready changes at the falling edge, beat checked before the rising edge
  initial begin
    rsp_t want;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(0, 99) >= sink_stall);
      #1;
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected beat %p", $time, rsp_if.data);
          fail_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_if.data.status !== want.status) begin
            $display("%0t status want %0d got %0d", $time, want.status, rsp_if.data.status);
            fail_cnt++;
          end
          if (rsp_if.data.grant_address !== want.grant_address) begin
            $display("%0t grant_address want %h got %h", $time, want.grant_address,
                     rsp_if.data.grant_address);
            fail_cnt++;
          end
          if (rsp_if.data.granted_size !== want.granted_size) begin
            $display("%0t granted_size want %h got %h", $time, want.granted_size,
                     rsp_if.data.granted_size);
            fail_cnt++;
          end
          if (rsp_if.data.free_entries !== want.free_entries) begin
            $display("%0t free_entries want %0d got %0d", $time, want.free_entries,
                     rsp_if.data.free_entries);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic vector_t mk(logic k, int sz, int ad);
    vector_t v;
    v.req   = '{k, 16'(sz), 16'(ad)};
    v.typed = 0;
    v.want  = '0;
    return v;
  endfunction

  function automatic vector_t mk_typed(logic k, int sz, int ad, logic [1:0] st, int ga, int gs,
                                       int ne);
    vector_t v;
    v       = mk(k, sz, ad);
    v.typed = 1;
    v.want  = '{st, 16'(ga), 16'(gs), 5'(ne)};
    return v;
  endfunction

  function automatic vector_t random_req();
    int     pick, n;
    block_t b;
    pick = $urandom_range(0, 99);
    if (part_cnt == 0 && granted_pool.size() == 0)
      return mk(KindRelease, $urandom_range(256, 8192), $urandom_range(0, 16'hC000));
    if (pick < 45)
      return mk(KindAlloc, $urandom_range(1, 600), $urandom);
    if (pick < 85 && granted_pool.size() != 0) begin
      n = $urandom_range(0, granted_pool.size() - 1);
      b = granted_pool[n];
      granted_pool.delete(n);
      return mk(KindRelease, b.len, b.base);
    end
    if (pick < 92)
      return mk(KindRelease, $urandom_range(0, 65535), $urandom_range(0, 65535));
    return mk(KindAlloc, $urandom_range(0, 65535), $urandom);
  endfunction

  task automatic wait_idle();
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  vector_t directed[$];

  initial begin
    int split_vals[6];
    int mode_vals[6];
    int stall_src[4];
    int stall_sink[4];
    split_vals = '{0, 65535, 8, 16, 0, 65535};
    mode_vals  = '{ModeNext, ModeBest, ModeBest, ModeNext, ModeBest, ModeNext};
    stall_src  = '{0, 68, 0, 32};
    stall_sink = '{0, 0, 68, 32};
    part_base  = '{default: '0};
    part_len   = '{default: '0};
    part_cnt   = 0;
    rover_idx  = 0;
    split_min  = '0;
    mode_best  = ModeNext;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    src_idle   = 0;
    sink_stall = 0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_ni     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed.push_back(mk_typed(KindAlloc, 16, 0, StatNoFit, 0, 0, 0));       // empty table
    directed.push_back(mk_typed(KindAlloc, 0, 16'hFFFF, StatNoFit, 0, 0, 0)); // zero size
    directed.push_back(mk_typed(KindRelease, 0, 16'h1234, StatOk, 0, 0, 0));  // zero release
    directed.push_back(mk_typed(KindRelease, 16'hFFFF, 0, StatOk, 0, 0, 1));
    directed.push_back(mk_typed(KindAlloc, 16'hFFFF, 0, StatOk, 0, 16'hFFFF, 0));
    directed.push_back(mk_typed(KindRelease, 16'hFFFF, 0, StatOk, 0, 0, 1));
    // merge below would overflow, so a second entry appears
    directed.push_back(mk_typed(KindRelease, 1, 16'hFFFF, StatOk, 0, 0, 2));
    directed.push_back(mk_typed(KindAlloc, 16'hFFFF, 0, StatOk, 0, 16'hFFFF, 1));
    directed.push_back(mk(KindAlloc, 1, 0));
    directed.push_back(mk(KindAlloc, 16'h7FFF, 0));
    directed.push_back(mk(KindAlloc, 1, 0));
    directed.push_back(mk(KindRelease, 1, 16'h8000));   // isolated block, new entry
    directed.push_back(mk(KindRelease, 1, 0));
    directed.push_back(mk(KindAlloc, 16'h0100, 16'hAAAA));
    directed.push_back(mk(KindAlloc, 16'h0200, 16'h5555));
    directed.push_back(mk(KindRelease, 16'h0100, 16'h0001));
    directed.push_back(mk(KindAlloc, 16'h0010, 0));
    directed.push_back(mk(KindRelease, 16'h0010, 16'h0101));
    directed.push_back(mk(KindAlloc, 16'hFFFE, 0));
    directed.push_back(mk(KindAlloc, 16'h8000, 0));
    directed.push_back(mk(KindRelease, 16'h8000, 16'h7FFF));
    foreach (directed[i]) send_req(directed[i]);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      apb_write(RegMinSplit, split_vals[ph]);
      apb_write(RegFitMode, mode_vals[ph]);
      src_idle   = stall_src[ph % 4];
      sink_stall = stall_sink[ph % 4];
      for (int n = 0; n < 225; n++) send_req(random_req());
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
